>>> hw/rtl/tsdc_pkg.sv
// Package for the two-sensor direction counter.
// Holds transaction payload types, phase codes, register indexes and reset values.
// No dependencies.
package tsdc_pkg;

   localparam int unsigned SampleWidth  = 10;
   localparam int unsigned ElapsedWidth = 10;
   localparam int unsigned TimeWidth    = 16;
   localparam int unsigned CountWidth   = 32;
   localparam int unsigned PhaseWidth   = 3;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 16;

   // Register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CSR_LEVEL_THRESHOLD = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DIRECTION_TMO   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_HOLD            = 2'd2;

   localparam logic [SampleWidth-1:0] LEVEL_THRESHOLD_RST = 10'd300;
   localparam logic [TimeWidth-1:0]   DIRECTION_TMO_RST   = 16'd2000;
   localparam logic [TimeWidth-1:0]   HOLD_RST            = 16'd5;

   // Phase codes as seen on the result channel
   localparam logic [PhaseWidth-1:0] PHASE_CODE_IDLE  = 3'd0;
   localparam logic [PhaseWidth-1:0] PHASE_CODE_LEFT  = 3'd1;
   localparam logic [PhaseWidth-1:0] PHASE_CODE_RIGHT = 3'd2;
   localparam logic [PhaseWidth-1:0] PHASE_CODE_IN    = 3'd3;
   localparam logic [PhaseWidth-1:0] PHASE_CODE_OUT   = 3'd4;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_LEFT  = 5'b00010,
      PH_RIGHT = 5'b00100,
      PH_IN    = 5'b01000,
      PH_OUT   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [SampleWidth-1:0]  left_sample;
      logic [SampleWidth-1:0]  right_sample;
      logic [ElapsedWidth-1:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic                         entered;
      logic                         exited;
      logic signed [CountWidth-1:0] occupancy;
      logic [PhaseWidth-1:0]        phase;
   } rsp_type;

endpackage

>>> hw/rtl/two_sensor_direction_counter.sv
// Two-sensor direction counter top level.
// Input register, phase machine and result register; uses tsdc_pkg.
//
// Takes one sample pair per transaction and returns one result per transaction.
// A transaction is held in the input register, where the phase machine
// evaluates it against the stored phase, time and count, and the result moves
// to the output register; a new transaction is accepted every cycle while the
// result side keeps up. Configuration writes take effect on the next cycle;
// make them only while no transaction is in flight.
module two_sensor_direction_counter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tsdc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tsdc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [tsdc_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [tsdc_pkg::CsrDataWidth-1:0]    csr_wr_data
);

   logic [tsdc_pkg::SampleWidth-1:0] threshold_ff;
   logic [tsdc_pkg::TimeWidth-1:0]   dir_tmo_ff;
   logic [tsdc_pkg::TimeWidth-1:0]   hold_ff;

   logic              stage_valid_ff;
   tsdc_pkg::req_type stage_data_ff;
   logic              rsp_valid_ff;
   tsdc_pkg::rsp_type rsp_data_ff;
   tsdc_pkg::rsp_type rsp_data_in;

   tsdc_pkg::phase_type             phase_ff, phase_in;
   logic [tsdc_pkg::TimeWidth-1:0]  time_ff, time_in;
   logic [tsdc_pkg::CountWidth-1:0] count_ff, count_in;

   logic                            advance;
   logic                            left_blk, right_blk, left_only, right_only;
   logic [tsdc_pkg::TimeWidth:0]    time_sum;
   logic [tsdc_pkg::TimeWidth-1:0]  time_sat;
   logic                            ent, ext;
   logic [tsdc_pkg::PhaseWidth-1:0] phase_code;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tsdc_pkg::LEVEL_THRESHOLD_RST;
         dir_tmo_ff   <= tsdc_pkg::DIRECTION_TMO_RST;
         hold_ff      <= tsdc_pkg::HOLD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            tsdc_pkg::CSR_LEVEL_THRESHOLD: begin
               threshold_ff <= csr_wr_data[tsdc_pkg::SampleWidth-1:0];
            end
            tsdc_pkg::CSR_DIRECTION_TMO: begin
               dir_tmo_ff <= csr_wr_data;
            end
            tsdc_pkg::CSR_HOLD: begin
               hold_ff <= csr_wr_data;
            end
            default: begin
               // drop writes outside the register list
            end
         endcase
      end
   end

   always_comb begin
      left_blk   = stage_data_ff.left_sample > threshold_ff;
      right_blk  = stage_data_ff.right_sample > threshold_ff;
      left_only  = left_blk && !right_blk;
      right_only = right_blk && !left_blk;
      time_sum   = {1'b0, time_ff} +
                   {{(tsdc_pkg::TimeWidth + 1 - tsdc_pkg::ElapsedWidth){1'b0}},
                    stage_data_ff.elapsed_ms};
      time_sat   = time_sum[tsdc_pkg::TimeWidth] ? {tsdc_pkg::TimeWidth{1'b1}}
                                                 : time_sum[tsdc_pkg::TimeWidth-1:0];
      phase_in   = phase_ff;
      count_in   = count_ff;
      ent        = 1'b0;
      ext        = 1'b0;
      case (phase_ff)
         tsdc_pkg::PH_IDLE: begin
            if (left_only) begin
               phase_in = tsdc_pkg::PH_LEFT;
            end else if (right_only) begin
               phase_in = tsdc_pkg::PH_RIGHT;
            end
         end
         tsdc_pkg::PH_LEFT: begin
            if (right_only) begin
               phase_in = tsdc_pkg::PH_IN;
               ent      = 1'b1;
               count_in = count_ff + 32'd1;
            end else if (time_sat >= dir_tmo_ff) begin
               phase_in = tsdc_pkg::PH_IDLE;
            end
         end
         tsdc_pkg::PH_RIGHT: begin
            if (left_only) begin
               phase_in = tsdc_pkg::PH_OUT;
               ext      = 1'b1;
               count_in = count_ff - 32'd1;
            end else if (time_sat >= dir_tmo_ff) begin
               phase_in = tsdc_pkg::PH_IDLE;
            end
         end
         tsdc_pkg::PH_IN, tsdc_pkg::PH_OUT: begin
            if (time_sat >= hold_ff) begin
               phase_in = tsdc_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = tsdc_pkg::PH_IDLE;
         end
      endcase
      // clear the phase timer on every transition
      time_in = (phase_in != phase_ff) ? '0 : time_sat;

      case (phase_in)
         tsdc_pkg::PH_LEFT:  phase_code = tsdc_pkg::PHASE_CODE_LEFT;
         tsdc_pkg::PH_RIGHT: phase_code = tsdc_pkg::PHASE_CODE_RIGHT;
         tsdc_pkg::PH_IN:    phase_code = tsdc_pkg::PHASE_CODE_IN;
         tsdc_pkg::PH_OUT:   phase_code = tsdc_pkg::PHASE_CODE_OUT;
         default:            phase_code = tsdc_pkg::PHASE_CODE_IDLE;
      endcase

      rsp_data_in.entered   = ent;
      rsp_data_in.exited    = ext;
      rsp_data_in.occupancy = signed'(count_in);
      rsp_data_in.phase     = phase_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= tsdc_pkg::PH_IDLE;
         time_ff        <= '0;
         count_ff       <= '0;
      end else begin
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            time_ff      <= time_in;
            count_ff     <= count_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register lost its one-hot code");

   a_pulse_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.entered && rsp_data_ff.exited))
      else $error("entered and exited raised together");

   a_entered_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.entered |-> rsp_data_ff.phase == tsdc_pkg::PHASE_CODE_IN)
      else $error("entered pulse outside person in");

   a_count_inc: assert property (@(posedge clock) disable iff (reset)
      advance && ent |=> count_ff == $past(count_ff) + 32'd1)
      else $error("count did not advance on entry");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !advance |-> !req_ready)
      else $error("input register would be overwritten");
`endif

endmodule
